>>> sv/ksh_pkg.sv
// ----------------------------------------------------------------------------
// ksh_pkg
// Types and constants shared by the bounded max-heap selection block.
// ----------------------------------------------------------------------------
package ksh_pkg;

	localparam int VALUE_W = 32;
	localparam int KCFG_W  = 7;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} ksh_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_BUILD_NEXT,
		ST_ROOT_RD,
		ST_ROOT_CMP,
		ST_SIFT_RD,
		ST_SIFT_WAIT,
		ST_SIFT_CMP,
		ST_SIFT_SWAP,
		ST_SIFT_SWAP2,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} ksh_state_t;

endpackage

>>> sv/ksh_front.sv
// ----------------------------------------------------------------------------
// ksh_front
// Accepts input words and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ksh_front
	import ksh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [VALUE_W-1:0] value,
	input  logic               last,
	output logic               q_valid,
	output ksh_word_t          q_word,
	input  logic               q_pop
);

	ksh_word_t mem_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] cnt_q;
	logic      push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_word   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{value: value, last: last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

>>> sv/ksh_back.sv
// ----------------------------------------------------------------------------
// ksh_back
// Heap store and sequencer: fill, build, replace-and-sift, and emission.
// ----------------------------------------------------------------------------
module ksh_back
	import ksh_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [KCFG_W-1:0]  k_count,
	input  logic               q_valid,
	input  ksh_word_t          q_word,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] kept_value,
	output logic               final_res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = AW + 2;

	logic [VALUE_W-1:0] mem [CAPACITY];

	ksh_state_t state_q, state_d;
	logic [CW-1:0] fill_q;
	logic          built_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] bidx_q;
	logic          building_q;
	logic          replace_q;
	logic          emit_after_q;
	logic [1:0]    rd_step_q;
	logic [VALUE_W-1:0] cand_q;
	logic [VALUE_W-1:0] pv_q, lv_q, rv_q;
	logic [VALUE_W-1:0] rd_data_q;
	logic          out_valid_q;
	logic [VALUE_W-1:0] out_val_q;
	logic          out_fin_q;
	logic [CW-1:0] eidx_q;

	logic [CW-1:0] keff;
	logic [CW-1:0] fill_inc;
	logic [CW-1:0] eidx_inc;
	logic [PW-1:0] lidx, ridx;
	logic          l_ok, r_ok, pick_l, pick_r;
	logic          do_fill;
	logic          fill_done;
	logic          root_gt;
	logic          more_nodes;
	logic          last_emit;
	logic          out_load;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [VALUE_W-1:0] wdata;

	always_comb begin
		if (k_count == '0) begin
			keff = CW'(1);
		end else if ({{(32-KCFG_W){1'b0}}, k_count} > 32'(CAPACITY)) begin
			keff = CW'(CAPACITY);
		end else begin
			keff = CW'(k_count);
		end
	end

	assign fill_inc   = fill_q + CW'(1);
	assign eidx_inc   = eidx_q + CW'(1);
	assign lidx       = {1'b0, pos_q, 1'b1};
	assign ridx       = {1'b0, pos_q, 1'b0} + PW'(2);
	assign l_ok       = lidx < PW'(fill_q);
	assign r_ok       = ridx < PW'(fill_q);
	assign pick_l     = l_ok && ($signed(lv_q) > $signed(pv_q));
	assign pick_r     = r_ok && ($signed(rv_q) > $signed(pick_l ? lv_q : pv_q));
	assign do_fill    = !built_q && (fill_q < keff);
	assign fill_done  = fill_inc >= keff;
	assign root_gt    = $signed(rd_data_q) > $signed(cand_q);
	assign more_nodes = building_q && (bidx_q != '0);
	assign last_emit  = (eidx_inc == fill_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				if (q_valid) begin
					if (do_fill) begin
						state_d = (fill_done || q_word.last) ? ST_SIFT_RD : ST_DISPATCH;
					end else begin
						state_d = built_q ? ST_ROOT_RD : ST_SIFT_RD;
					end
				end
			end
			ST_BUILD_NEXT: begin
				priority if (more_nodes) begin
					state_d = ST_SIFT_RD;
				end else if (replace_q) begin
					state_d = ST_ROOT_RD;
				end else if (emit_after_q) begin
					state_d = ST_EMIT_RD;
				end else begin
					state_d = ST_DISPATCH;
				end
			end
			ST_ROOT_RD:    state_d = ST_ROOT_CMP;
			ST_ROOT_CMP:   state_d = root_gt ? ST_SIFT_RD : ST_BUILD_NEXT;
			ST_SIFT_RD:    state_d = (rd_step_q == 2'd2) ? ST_SIFT_WAIT : ST_SIFT_RD;
			ST_SIFT_WAIT:  state_d = ST_SIFT_CMP;
			ST_SIFT_CMP:   state_d = (pick_l || pick_r) ? ST_SIFT_SWAP : ST_BUILD_NEXT;
			ST_SIFT_SWAP:  state_d = ST_SIFT_SWAP2;
			ST_SIFT_SWAP2: state_d = ST_SIFT_RD;
			ST_EMIT_RD:    state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (out_load) begin
					state_d = last_emit ? ST_DISPATCH : ST_EMIT_RD;
				end
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == ST_DISPATCH) && q_valid;
		out_load = (state_q == ST_EMIT_OUT) && (!out_valid_q || !out_stall);
		we       = 1'b0;
		waddr    = pos_q;
		wdata    = pv_q;
		raddr    = pos_q;
		unique case (state_q)
			ST_DISPATCH: begin
				if (q_valid && do_fill) begin
					we    = 1'b1;
					waddr = fill_q[AW-1:0];
					wdata = q_word.value;
				end
			end
			ST_ROOT_RD: begin
				raddr = '0;
			end
			ST_ROOT_CMP: begin
				if (root_gt) begin
					we    = 1'b1;
					waddr = '0;
					wdata = cand_q;
				end
			end
			ST_SIFT_RD: begin
				unique case (rd_step_q)
					2'd0:    raddr = pos_q;
					2'd1:    raddr = lidx[AW-1:0];
					default: raddr = ridx[AW-1:0];
				endcase
			end
			ST_SIFT_SWAP: begin
				we    = 1'b1;
				wdata = pick_r ? rv_q : lv_q;
			end
			ST_SIFT_SWAP2: begin
				we = 1'b1;
			end
			ST_EMIT_RD, ST_EMIT_OUT: begin
				raddr = eidx_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign kept_value = out_val_q;
	assign final_res  = out_fin_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			built_q      <= 1'b0;
			pos_q        <= '0;
			bidx_q       <= '0;
			building_q   <= 1'b0;
			replace_q    <= 1'b0;
			emit_after_q <= 1'b0;
			rd_step_q    <= 2'd0;
			cand_q       <= '0;
			pv_q         <= '0;
			lv_q         <= '0;
			rv_q         <= '0;
			out_valid_q  <= 1'b0;
			out_val_q    <= '0;
			out_fin_q    <= 1'b0;
			eidx_q       <= '0;
		end else begin
			state_q   <= state_d;
			rd_step_q <= (state_q == ST_SIFT_RD) ? rd_step_q + 2'd1 : 2'd0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_DISPATCH: begin
					if (q_valid) begin
						cand_q       <= q_word.value;
						emit_after_q <= q_word.last;
						if (do_fill) begin
							fill_q     <= fill_inc;
							building_q <= fill_done || q_word.last;
							replace_q  <= 1'b0;
							bidx_q     <= AW'(fill_q >> 1);
							pos_q      <= AW'(fill_q >> 1);
							if (fill_done) begin
								built_q <= 1'b1;
							end
						end else if (!built_q) begin
							built_q    <= 1'b1;
							building_q <= 1'b1;
							replace_q  <= 1'b1;
							bidx_q     <= AW'((fill_q - CW'(1)) >> 1);
							pos_q      <= AW'((fill_q - CW'(1)) >> 1);
						end else begin
							building_q <= 1'b0;
							replace_q  <= 1'b0;
						end
					end
				end
				ST_BUILD_NEXT: begin
					priority if (more_nodes) begin
						bidx_q <= bidx_q - AW'(1);
						pos_q  <= bidx_q - AW'(1);
					end else if (replace_q) begin
						building_q <= 1'b0;
						replace_q  <= 1'b0;
					end else begin
						building_q <= 1'b0;
						eidx_q     <= '0;
					end
				end
				ST_ROOT_CMP: begin
					pos_q <= '0;
				end
				ST_SIFT_RD: begin
					if (rd_step_q == 2'd1) begin
						pv_q <= rd_data_q;
					end
					if (rd_step_q == 2'd2) begin
						lv_q <= rd_data_q;
					end
				end
				ST_SIFT_WAIT: begin
					rv_q <= rd_data_q;
				end
				ST_SIFT_SWAP: begin
					pos_q <= pick_r ? ridx[AW-1:0] : lidx[AW-1:0];
				end
				ST_EMIT_OUT: begin
					if (out_load) begin
						out_val_q <= rd_data_q;
						out_fin_q <= last_emit;
						eidx_q    <= eidx_inc;
						if (last_emit) begin
							fill_q       <= '0;
							built_q      <= 1'b0;
							emit_after_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> sv/ksh_swapw.sv
// ----------------------------------------------------------------------------
// ksh_swapw
// Configuration register: holds k_count, written from the cfg channel and
// reset to one.
// ----------------------------------------------------------------------------
module ksh_swapw
	import ksh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [KCFG_W-1:0]  cfg_data,
	output logic [KCFG_W-1:0]  k_count
);

	logic [KCFG_W-1:0] k_q;

	assign cfg_ready = 1'b1;
	assign k_count   = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= KCFG_W'(1);
		end else if (cfg_valid) begin
			k_q <= cfg_data;
		end
	end

endmodule

>>> sv/k_smallest_by_bounded_max_heap.sv
// ----------------------------------------------------------------------------
// k_smallest_by_bounded_max_heap
// Keeps the k smallest signed words of a stream in a bounded max-heap and
// sends them out in heap order when the stream ends.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   value, last
// out       output     out_valid / out_stall kept_value, final_res
// cfg       input      cfg_valid / cfg_ready cfg_data (k_count)
//
// A word that only fills the store is written from the dispatch state; a word
// compared against the root and rejected passes the root read and compare.
// A sift reads the parent and both children in turn and swaps the parent with
// the larger child per level moved; a replacement first compares the root.
// The heap build runs one sift per internal node; emission sends the kept
// words in turn. Reset clears control state; entries are written before read.
// A full two-word input queue raises in_stall; out_stall holds the output.
// ----------------------------------------------------------------------------
module k_smallest_by_bounded_max_heap
	import ksh_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        value,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        kept_value,
	output logic               final_res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data
);

	logic        q_valid;
	logic        q_pop;
	ksh_word_t   q_word;
	logic [KCFG_W-1:0] k_count;

	ksh_swapw u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.k_count   (k_count)
	);

	ksh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.last     (last),
		.q_valid  (q_valid),
		.q_word   (q_word),
		.q_pop    (q_pop)
	);

	ksh_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.k_count    (k_count),
		.q_valid    (q_valid),
		.q_word     (q_word),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kept_value (kept_value),
		.final_res  (final_res)
	);

endmodule

>>> sim/k_smallest_by_bounded_max_heap_test.sv
// ----------------------------------------------------------------------------
// k_smallest_by_bounded_max_heap_test
// Drives streams of signed words with random gaps and stalls, predicts the
// kept heap contents with a behavioral bounded max-heap, and compares every
// emitted word against the prediction across several k settings.
// ----------------------------------------------------------------------------
module k_smallest_by_bounded_max_heap_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 64;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [31:0] kept_value;
		logic        final_res;
	} kept_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] value;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] kept_value;
	logic        final_res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	logic [31:0] heap_model [CAP];
	int unsigned held_count;
	bit          heap_ordered;
	logic [6:0]  k_setting;

	kept_word_t  pending_words [$];
	int          failures;
	int          words_checked;
	int          items_sent;
	int          streams_sent;
	longint      cycles;
	bit          stall_quiet;

	k_smallest_by_bounded_max_heap #(.CAPACITY(CAP)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kept_value (kept_value),
		.final_res  (final_res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
			$display("k_smallest_by_bounded_max_heap_test NOT OK");
			$finish;
		end
	end

	function automatic int unsigned active_k();
		if (k_setting == 0)
			return 1;
		if (k_setting > CAP)
			return CAP;
		return k_setting;
	endfunction

	function automatic void sift_node(int unsigned pos, int unsigned n);
		int unsigned lc;
		int unsigned rc;
		int unsigned big;
		logic [31:0] tmp;
		forever begin
			lc = 2 * pos + 1;
			rc = 2 * pos + 2;
			big = pos;
			if (lc < n && $signed(heap_model[lc]) > $signed(heap_model[big]))
				big = lc;
			if (rc < n && $signed(heap_model[rc]) > $signed(heap_model[big]))
				big = rc;
			if (big == pos)
				return;
			tmp = heap_model[pos];
			heap_model[pos] = heap_model[big];
			heap_model[big] = tmp;
			pos = big;
		end
	endfunction

	function automatic void heapify(int unsigned n);
		if (n == 0)
			return;
		for (int i = (n - 1) / 2; i >= 0; i--)
			sift_node(i, n);
	endfunction

	function automatic void predict_kept(logic [31:0] v, logic is_last);
		int unsigned kk;
		kept_word_t w;
		kk = active_k();
		if (!heap_ordered && held_count < kk) begin
			heap_model[held_count] = v;
			held_count++;
			if (held_count >= kk) begin
				heapify(held_count);
				heap_ordered = 1'b1;
			end
		end else begin
			if (!heap_ordered) begin
				heapify(held_count);
				heap_ordered = 1'b1;
			end
			if (held_count > 0 && $signed(heap_model[0]) > $signed(v)) begin
				heap_model[0] = v;
				sift_node(0, held_count);
			end
		end
		if (!is_last)
			return;
		if (!heap_ordered)
			heapify(held_count);
		for (int unsigned i = 0; i < held_count; i++) begin
			w.kept_value = heap_model[i];
			w.final_res = (i + 1 == held_count);
			pending_words.push_back(w);
		end
		held_count = 0;
		heap_ordered = 1'b0;
	endfunction

	function automatic int gap_length();
		if ($urandom_range(0, 2) == 0)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	always @(posedge clk) begin
		kept_word_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word kept_value=%0d final_res=%0b", $time,
					$signed(kept_value), final_res);
				failures++;
			end else begin
				exp_w = pending_words.pop_front();
				words_checked++;
				if (kept_value !== exp_w.kept_value) begin
					$display("%0t: kept_value expected %0d actual %0d", $time,
						$signed(exp_w.kept_value), $signed(kept_value));
					failures++;
				end
				if (final_res !== exp_w.final_res) begin
					$display("%0t: final_res expected %0b actual %0b", $time,
						exp_w.final_res, final_res);
					failures++;
				end
			end
		end
	end

	initial begin
		int g;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			g = stall_quiet ? 0 : gap_length();
			if (g == 0) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				repeat (g) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(logic [31:0] v, logic is_last, bit no_gap = 0);
		int g;
		g = no_gap ? 0 : gap_length();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_kept(v, is_last);
		items_sent++;
		if (is_last)
			streams_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_k(logic [6:0] k);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		k_setting = k;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_stream(int n);
		for (int i = 0; i < n; i++)
			send_item(rand_value(), i == n - 1);
	endtask

	task automatic test_reset_k();
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b1);
	endtask

	task automatic test_extremes();
		write_k(7'd4);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'h5555_5555, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b0);
		send_item(32'h8000_0000, 1'b1);
		send_item(32'h1234_5678, 1'b0);
		send_item(32'h1234_5678, 1'b1);
		send_item(32'h0000_0001, 1'b1);
	endtask

	task automatic test_k_zero_and_saturate();
		write_k(7'd0);
		send_stream(3);
		write_k(7'd127);
		send_stream(70);
		write_k(7'd64);
		send_stream(5);
	endtask

	task automatic test_k_lowered_mid_fill();
		write_k(7'd8);
		send_item(32'd5, 1'b0);
		send_item(32'd9, 1'b0);
		send_item(32'd1, 1'b0);
		send_item(32'd7, 1'b0);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= 7'd2;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		k_setting = 7'd2;
		@(negedge clk);
		cfg_valid <= 1'b0;
		send_item(32'd3, 1'b0);
		send_item(32'd0, 1'b1);
	endtask

	task automatic test_random_streams();
		int n;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_k(7'd1);
				1: write_k(7'($urandom_range(2, 6)));
				2: write_k(7'($urandom_range(7, 20)));
				default: write_k(7'd3);
			endcase
			for (int s = 0; s < 4; s++) begin
				n = $urandom_range(1, 2 * active_k() + 4);
				stall_quiet = (s == 2);
				send_stream(n);
				if (s == 3)
					drain_results();
			end
			stall_quiet = 1'b0;
		end
		while (items_sent < 210) begin
			n = $urandom_range(1, 12);
			send_stream(n);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		last = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		held_count = 0;
		heap_ordered = 1'b0;
		k_setting = 7'd1;
		failures = 0;
		words_checked = 0;
		items_sent = 0;
		streams_sent = 0;
		cycles = 0;
		stall_quiet = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_k();
		test_extremes();
		test_k_zero_and_saturate();
		test_k_lowered_mid_fill();
		test_random_streams();
		drain_results();

		$display("Covered %0d items in %0d streams, %0d kept words checked,", items_sent,
			streams_sent, words_checked);
		$display("with k at 0, 1, small, mid, 64, 127 and lowered during filling.");
		if (failures == 0) begin
			$display("k_smallest_by_bounded_max_heap_test OK");
		end else begin
			$display("k_smallest_by_bounded_max_heap_test NOT OK");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/ksh_pkg.sv
sv/ksh_front.sv
sv/ksh_back.sv
sv/ksh_swapw.sv
sv/k_smallest_by_bounded_max_heap.sv
sim/k_smallest_by_bounded_max_heap_test.sv
